### src/tesn_pkg.sv
// Shared types and constants for the text encoding and end-of-line sniffer.
// Used by the result channel interface and every module of the block.
package tesn_pkg;

  localparam int WINDOW_BYTES = 4096;

  localparam int POS_W  = $clog2(WINDOW_BYTES);
  localparam int BW_W   = $clog2(WINDOW_BYTES + 1);
  localparam int PAIR_W = $clog2(WINDOW_BYTES / 2 + 1);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_BYTES - 1);

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  localparam int CODE_W = 3;

  typedef enum logic [2:0] {
    ENC_BINARY    = 3'd0,
    ENC_UTF8      = 3'd1,
    ENC_UTF8_BOM  = 3'd2,
    ENC_U16BE     = 3'd3,
    ENC_U16BE_BOM = 3'd4,
    ENC_U16LE     = 3'd5,
    ENC_U16LE_BOM = 3'd6
  } enc_t;

  // Also used as "ending index plus one" for a classified lead byte.
  typedef enum logic [2:0] {
    EOL_NONE = 3'd0,
    EOL_CR   = 3'd1,
    EOL_CRLF = 3'd2,
    EOL_LF   = 3'd3,
    EOL_LFCR = 3'd4
  } eol_t;

  typedef enum logic [1:0] {
    MARK_NONE = 2'd0,
    MARK_UTF8 = 2'd1,
    MARK_BE   = 2'd2,
    MARK_LE   = 2'd3
  } mark_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } byte_item_t;

  // Counts of one finished window, handed from the counters to the decision stage.
  typedef struct packed {
    mark_t                      mark;
    logic [PAIR_W-1:0]          even_zeros;
    logic [PAIR_W-1:0]          odd_zeros;
    logic [BW_W-1:0]            ctrl_count;
    logic [3:0][BW_W-1:0]       bw_counts;
    logic [3:0][PAIR_W-1:0]     be_counts;
    logic [3:0][PAIR_W-1:0]     le_counts;
  } tally_t;

endpackage

### src/tesn_byte_if.sv
// Input byte channel: valid/ready handshake carrying one window byte.
interface tesn_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

### src/tesn_result_if.sv
// Result channel: valid/ready handshake carrying encoding and line-end codes.
// Depends on tesn_pkg for the code width.
interface tesn_result_if;
  import tesn_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] encoding_code;
  logic [CODE_W-1:0] line_end_code;

  modport source (output valid, output encoding_code, output line_end_code, input ready);
  modport sink   (input valid, input encoding_code, input line_end_code, output ready);
endinterface

### src/text_encoding_and_eol_sniffer_top.sv
// Top level of the text encoding and end-of-line sniffer: input register,
// per-byte counters and the decision stage. Depends on tesn_pkg and the channel interfaces.
//
// Bytes of a text window enter one per cycle, back to back, with is_last on
// the final byte; a window also closes by itself at its WINDOW_BYTES-th byte.
// Each byte updates shallow counters, so the sustained rate is one byte per
// clock. After the closing byte's transfer it passes the input register, its
// counts are caught in a snapshot register, and the decision stage registers
// the single result (encoding code and line-end code) for output. The next
// window's bytes are taken meanwhile; only a closing byte waits, and only
// while an earlier result still sits unread in both the snapshot and output
// registers.
module text_encoding_and_eol_sniffer_top (
  input  logic          clk,
  input  logic          rst,
  tesn_byte_if.sink     text,
  tesn_result_if.source verdict
);
  import tesn_pkg::*;

  logic       held_valid;
  byte_item_t held;
  logic       held_take;
  logic       snap_valid;
  tally_t     snap;
  logic       snap_take;

  assign text.ready = !held_valid || held_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      held_valid <= 1'b1;
    end else if (held_take) begin
      held_valid <= 1'b0;
    end
  end

  // Capture each transfer into the input register
  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      held.data_byte <= text.data_byte;
      held.is_last   <= text.is_last;
    end
  end

  tesn_count u_count (
    .clk        (clk),
    .rst        (rst),
    .item_valid (held_valid),
    .item       (held),
    .item_take  (held_take),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_take  (snap_take)
  );

  tesn_decide u_decide (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_take  (snap_take),
    .result     (verdict)
  );

endmodule

### src/tesn_count.sv
// Per-byte counters: byte-order mark, zero and control counts, line endings
// in the byte-wise and both UTF-16 layouts. Snapshots the counts at window end.
// Depends on tesn_pkg.
module tesn_count (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  tesn_pkg::byte_item_t item,
  output logic                item_take,
  output logic                snap_valid,
  output tesn_pkg::tally_t    snap,
  input  logic                snap_take
);
  import tesn_pkg::*;

  function automatic logic is_control(input logic [7:0] b);
    is_control = (b != 8'd0) && ((b <= 8'd8) || ((b >= 8'd14) && (b <= 8'd31)));
  endfunction

  function automatic eol_t classify(input logic [7:0] lead, input logic zero_hi,
                                    input logic [7:0] nxt);
    eol_t c;
    c = EOL_NONE;
    if (lead == CH_CR) begin
      c = (zero_hi && nxt == CH_LF) ? EOL_CRLF : EOL_CR;
    end else if (lead == CH_LF) begin
      c = (zero_hi && nxt == CH_CR) ? EOL_LFCR : EOL_LF;
    end
    classify = c;
  endfunction

  logic [POS_W-1:0]      pos;
  logic [3:0][7:0]       recent;
  mark_t                 mark;
  logic [PAIR_W-1:0]     even_zeros;
  logic [PAIR_W-1:0]     odd_zeros;
  logic [BW_W-1:0]       ctrl_count;
  logic [3:0][BW_W-1:0]  bw_counts;
  logic [3:0][PAIR_W-1:0] be_counts;
  logic [3:0][PAIR_W-1:0] le_counts;
  eol_t                  pend_be;
  eol_t                  pend_le;

  logic [3:0][7:0]       recent_next;
  mark_t                 mark_next;
  logic [PAIR_W-1:0]     even_zeros_next;
  logic [PAIR_W-1:0]     odd_zeros_next;
  logic [BW_W-1:0]       ctrl_count_next;
  logic [3:0][BW_W-1:0]  bw_counts_next;
  logic [3:0][PAIR_W-1:0] be_counts_next;
  logic [3:0][PAIR_W-1:0] le_counts_next;
  eol_t                  pend_be_next;
  eol_t                  pend_le_next;

  eol_t code_bw, be_bump, le_bump, fin_be, fin_le, fin_bw_a, fin_bw_b;
  logic pair_step;
  logic win_end;

  always_comb begin
    recent_next = {item.data_byte, recent[3], recent[2], recent[1]};
    win_end     = item.is_last || (pos == LAST_POS);

    mark_next = mark;
    if (pos == POS_W'(1)) begin
      if (recent_next[2] == 8'd254 && recent_next[3] == 8'd255) begin
        mark_next = MARK_BE;
      end else if (recent_next[2] == 8'd255 && recent_next[3] == 8'd254) begin
        mark_next = MARK_LE;
      end
    end else if (pos == POS_W'(2)) begin
      if (recent_next[1] == 8'd239 && recent_next[2] == 8'd187 &&
          recent_next[3] == 8'd191) begin
        mark_next = MARK_UTF8;
      end
    end

    code_bw = (pos >= POS_W'(2)) ? classify(recent_next[1], 1'b1, recent_next[2]) : EOL_NONE;

    even_zeros_next = even_zeros;
    odd_zeros_next  = odd_zeros;
    ctrl_count_next = ctrl_count;
    if (pos[0]) begin
      if (recent_next[2] == 8'd0) begin
        even_zeros_next = even_zeros + PAIR_W'(1);
      end
      if (recent_next[3] == 8'd0) begin
        odd_zeros_next = odd_zeros + PAIR_W'(1);
      end
      ctrl_count_next = ctrl_count + BW_W'(is_control(recent_next[2]))
                                   + BW_W'(is_control(recent_next[3]));
    end

    // A pair ending is committed one pair late, once its follower pair is seen
    pair_step    = pos[0] && (pos >= POS_W'(3));
    be_bump      = pair_step ? pend_be : EOL_NONE;
    le_bump      = pair_step ? pend_le : EOL_NONE;
    pend_be_next = pend_be;
    pend_le_next = pend_le;
    if (pair_step) begin
      pend_be_next = (recent_next[0] == 8'd0) ?
        classify(recent_next[1], recent_next[2] == 8'd0, recent_next[3]) : EOL_NONE;
      pend_le_next = (recent_next[1] == 8'd0) ?
        classify(recent_next[0], recent_next[3] == 8'd0, recent_next[2]) : EOL_NONE;
    end

    // Window close: flush pending pair endings if any mark, trailing leads if a UTF-8 mark
    fin_be   = (win_end && mark_next != MARK_NONE) ? pend_be_next : EOL_NONE;
    fin_le   = (win_end && mark_next != MARK_NONE) ? pend_le_next : EOL_NONE;
    fin_bw_a = (win_end && mark_next == MARK_UTF8) ?
               classify(recent_next[2], 1'b1, recent_next[3]) : EOL_NONE;
    fin_bw_b = (win_end && mark_next == MARK_UTF8) ?
               classify(recent_next[3], 1'b1, 8'd0) : EOL_NONE;

    for (int i = 0; i < 4; i++) begin
      bw_counts_next[i] = bw_counts[i]
        + BW_W'(code_bw  == eol_t'(3'(i + 1)))
        + BW_W'(fin_bw_a == eol_t'(3'(i + 1)))
        + BW_W'(fin_bw_b == eol_t'(3'(i + 1)));
      be_counts_next[i] = be_counts[i]
        + PAIR_W'(be_bump == eol_t'(3'(i + 1)))
        + PAIR_W'(fin_be  == eol_t'(3'(i + 1)));
      le_counts_next[i] = le_counts[i]
        + PAIR_W'(le_bump == eol_t'(3'(i + 1)))
        + PAIR_W'(fin_le  == eol_t'(3'(i + 1)));
    end
  end

  // A closing byte waits until the snapshot slot is free
  assign item_take = item_valid && (!win_end || !snap_valid || snap_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      recent     <= '0;
      mark       <= MARK_NONE;
      even_zeros <= '0;
      odd_zeros  <= '0;
      ctrl_count <= '0;
      bw_counts  <= '0;
      be_counts  <= '0;
      le_counts  <= '0;
      pend_be    <= EOL_NONE;
      pend_le    <= EOL_NONE;
      snap_valid <= 1'b0;
    end else begin
      if (snap_valid && snap_take) begin
        snap_valid <= 1'b0;
      end
      if (item_take) begin
        if (win_end) begin
          pos        <= '0;
          recent     <= '0;
          mark       <= MARK_NONE;
          even_zeros <= '0;
          odd_zeros  <= '0;
          ctrl_count <= '0;
          bw_counts  <= '0;
          be_counts  <= '0;
          le_counts  <= '0;
          pend_be    <= EOL_NONE;
          pend_le    <= EOL_NONE;
          snap_valid <= 1'b1;
        end else begin
          pos        <= pos + POS_W'(1);
          recent     <= recent_next;
          mark       <= mark_next;
          even_zeros <= even_zeros_next;
          odd_zeros  <= odd_zeros_next;
          ctrl_count <= ctrl_count_next;
          bw_counts  <= bw_counts_next;
          be_counts  <= be_counts_next;
          le_counts  <= le_counts_next;
          pend_be    <= pend_be_next;
          pend_le    <= pend_le_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && win_end) begin
      snap.mark       <= mark_next;
      snap.even_zeros <= even_zeros_next;
      snap.odd_zeros  <= odd_zeros_next;
      snap.ctrl_count <= ctrl_count_next;
      snap.bw_counts  <= bw_counts_next;
      snap.be_counts  <= be_counts_next;
      snap.le_counts  <= le_counts_next;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    item_take && win_end |=> pos == '0 && snap_valid)
    else $error("counters not cleared after window end");

  a_fresh_window: assert property (@(posedge clk) disable iff (rst)
    pos == '0 |-> mark == MARK_NONE && pend_be == EOL_NONE && pend_le == EOL_NONE)
    else $error("stale state at window start");

  a_snap_hold: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !snap_take |=> snap_valid && $stable(snap))
    else $error("snapshot changed before it was taken");

endmodule

### src/tesn_decide.sv
// Decision stage: picks the encoding from the window counts, then the line-end
// style from the matching layout, and holds the result for the output transfer.
// Depends on tesn_pkg and tesn_result_if.
module tesn_decide (
  input  logic             clk,
  input  logic             rst,
  input  logic             snap_valid,
  input  tesn_pkg::tally_t snap,
  output logic             snap_take,
  tesn_result_if.source    result
);
  import tesn_pkg::*;

  // Highest count wins, the earlier style wins a tie, all zero is unknown
  function automatic eol_t pick_eol(input logic [3:0][BW_W-1:0] c);
    logic [BW_W-1:0] best;
    eol_t            code;
    best = c[0];
    code = EOL_CR;
    if (c[1] > best) begin best = c[1]; code = EOL_CRLF; end
    if (c[2] > best) begin best = c[2]; code = EOL_LF;   end
    if (c[3] > best) begin best = c[3]; code = EOL_LFCR; end
    pick_eol = (best == '0) ? EOL_NONE : code;
  endfunction

  enc_t                 enc;
  eol_t                 eol;
  logic [3:0][BW_W-1:0] layout;

  always_comb begin
    case (snap.mark)
      MARK_UTF8: enc = ENC_UTF8_BOM;
      MARK_BE:   enc = ENC_U16BE_BOM;
      MARK_LE:   enc = ENC_U16LE_BOM;
      default: begin
        if (snap.even_zeros < (snap.odd_zeros >> 3)) begin
          enc = ENC_U16LE;
        end else if (snap.odd_zeros < (snap.even_zeros >> 3)) begin
          enc = ENC_U16BE;
        end else if (snap.ctrl_count == '0) begin
          enc = ENC_UTF8;
        end else begin
          enc = ENC_BINARY;
        end
      end
    endcase

    for (int i = 0; i < 4; i++) begin
      case (enc)
        ENC_U16BE, ENC_U16BE_BOM: layout[i] = BW_W'(snap.be_counts[i]);
        ENC_U16LE, ENC_U16LE_BOM: layout[i] = BW_W'(snap.le_counts[i]);
        default:                  layout[i] = snap.bw_counts[i];
      endcase
    end

    eol = (enc == ENC_BINARY) ? EOL_NONE : pick_eol(layout);
  end

  assign snap_take = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (snap_take) begin
      result.valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take && snap_valid) begin
      result.encoding_code <= enc;
      result.line_end_code <= eol;
    end
  end

  a_bom_utf8: assert property (@(posedge clk) disable iff (rst)
    snap_valid && snap_take && snap.mark == MARK_UTF8 |=>
      result.valid && result.encoding_code == ENC_UTF8_BOM)
    else $error("UTF-8 mark not reported");

  a_binary_no_eol: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.encoding_code == ENC_BINARY |-> result.line_end_code == EOL_NONE)
    else $error("line-end style reported for binary data");

  a_load_only_on_snap: assert property (@(posedge clk) disable iff (rst)
    !result.valid && !snap_valid |=> !result.valid)
    else $error("result appeared without a window snapshot");

endmodule
